>>> hw/rtl/channel_range_partitioner_defines.svh
// Assertion helpers; expects clk and arst_n in the enclosing module.
`ifndef CHANNEL_RANGE_PARTITIONER_DEFINES_SVH
`define CHANNEL_RANGE_PARTITIONER_DEFINES_SVH

// same-cycle implication
`define CRP_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/crp_pkg.sv
`default_nettype none

package crp_pkg;

	localparam int MAX_CHANNELS = 4096;
	localparam int IDX_W        = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int PROD_W       = IDX_W + CNT_W;
	localparam int DIV_STEPS    = CNT_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
	localparam int KIND_W       = 2;
	localparam int MODE_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = CNT_W;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CHANNELS);

	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SIZE   = 2'd2;

	localparam logic POLICY_SPACED = 1'b0;
	localparam logic POLICY_GOOD   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              channel_good;
		logic [IDX_W-1:0]  range_index;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] range_start;
		logic [CNT_W-1:0] range_stop;
		logic [CNT_W-1:0] range_count;
		logic             index_error;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0]  target;
		logic              policy;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] quotient;
		logic             rem_nz;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SPLIT,
		ST_DIV,
		ST_STOPS,
		ST_Q1,
		ST_Q2
	} crp_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/crp_div.sv
`default_nettype none

module crp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  crp_pkg::div_req_t req,
	output crp_pkg::div_rsp_t rsp
);

	logic [crp_pkg::CNT_W-1:0]     rem_q;
	logic [crp_pkg::CNT_W-1:0]     quo_q;
	logic [crp_pkg::CNT_W-1:0]     divisor_q;
	logic [crp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          done_q;
	logic [crp_pkg::CNT_W:0]       shifted;
	logic [crp_pkg::CNT_W:0]       diff;
	logic                          ge;

	always_comb begin
		shifted = {rem_q, quo_q[crp_pkg::CNT_W-1]};
		ge      = shifted >= {1'b0, divisor_q};
		diff    = shifted - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= crp_pkg::DIV_CNT_W'(crp_pkg::DIV_STEPS);
		end else if (run_q) begin
			cnt_q <= cnt_q - crp_pkg::DIV_CNT_W'(1);
			if (cnt_q == crp_pkg::DIV_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[crp_pkg::CNT_W-1:0] : shifted[crp_pkg::CNT_W-1:0];
			quo_q <= {quo_q[crp_pkg::CNT_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = |rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/crp_ctrl.sv
`default_nettype none
`include "channel_range_partitioner_defines.svh"

module crp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  crp_pkg::item_t   item,
	input  crp_pkg::cfg_t    cfg,
	input  logic             cfg_touch,
	output logic             busy,
	output logic             out_valid,
	output crp_pkg::result_t out_item
);

	localparam int CW = crp_pkg::CNT_W;
	localparam int IW = crp_pkg::IDX_W;
	localparam int PW = crp_pkg::PROD_W;

	crp_pkg::crp_state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic          ready_q, ready_d;
	logic [CW-1:0] total_q, total_d;
	logic [CW-1:0] spacing_q, spacing_d;
	logic [IW-1:0] qidx_q, qidx_d;
	logic [CW-1:0] cur_q, cur_d;
	logic [IW-1:0] r_q, r_d;
	logic [CW-1:0] gcnt_q, gcnt_d;
	logic [CW-1:0] gtot_q, gtot_d;
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] r_ext;
	logic          split_done;

	logic          flag_mem [crp_pkg::MAX_CHANNELS];
	logic          flag_we;
	logic          flag_s1;
	logic [CW-1:0] stop_mem [crp_pkg::MAX_CHANNELS];
	logic          stop_we;
	logic [CW-1:0] lo_s1;
	logic [CW-1:0] hi_s1;
	logic [PW-1:0] prod_s1;

	logic          mode_cnt;
	logic          mode_size;
	logic [CW-1:0] t_sat;
	logic [CW-1:0] ceil_val;

	logic          idx_err;
	logic [PW:0]   stop_sum;
	logic [CW-1:0] sp_start;
	logic [CW-1:0] sp_stop;

	logic          walking;
	logic          fast_query;

	crp_pkg::div_req_t div_req;
	crp_pkg::div_rsp_t div_rsp;

	crp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// flag store: one write port for loads, one read port for the walks
	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[count_q[IW-1:0]] <= item.channel_good;
		end
		flag_s1 <= flag_mem[cur_d[IW-1:0]];
	end

	// range stop store: written by the walk, read at two places by a query
	always_ff @(posedge clk) begin
		if (stop_we) begin
			stop_mem[r_q] <= cur_q;
		end
		lo_s1   <= stop_mem[qidx_q - IW'(1)];
		hi_s1   <= stop_mem[qidx_q];
		prod_s1 <= PW'(qidx_q) * PW'(spacing_q);
	end

	always_comb begin
		mode_cnt  = (cfg.mode == crp_pkg::MODE_COUNT) && (cfg.target != '0);
		mode_size = (cfg.mode == crp_pkg::MODE_SIZE) && (cfg.target != '0);
		t_sat     = (cfg.target > crp_pkg::MAX_COUNT) ? crp_pkg::MAX_COUNT : cfg.target;
		ceil_val  = div_rsp.quotient + CW'(div_rsp.rem_nz);
		r_ext     = CW'(r_q);
	end

	always_comb begin
		idx_err  = CW'(qidx_q) >= total_q;
		stop_sum = (PW + 1)'(prod_s1) + (PW + 1)'(spacing_q);
		sp_start = (prod_s1 > PW'(count_q)) ? count_q : prod_s1[CW-1:0];
		sp_stop  = (stop_sum > (PW + 1)'(count_q)) ? count_q : stop_sum[CW-1:0];

		out_item.range_count = total_q;
		out_item.index_error = idx_err;
		if (idx_err) begin
			out_item.range_start = '0;
			out_item.range_stop  = '0;
		end else if (cfg.policy == crp_pkg::POLICY_SPACED) begin
			out_item.range_start = sp_start;
			out_item.range_stop  = sp_stop;
		end else begin
			out_item.range_start = (qidx_q == '0) ? '0 : lo_s1;
			out_item.range_stop  = hi_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= crp_pkg::ST_IDLE;
			count_q   <= '0;
			ready_q   <= 1'b0;
			total_q   <= '0;
			spacing_q <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ready_q   <= ready_d;
			total_q   <= total_d;
			spacing_q <= spacing_d;
		end
	end

	always_ff @(posedge clk) begin
		qidx_q <= qidx_d;
		cur_q  <= cur_d;
		r_q    <= r_d;
		gcnt_q <= gcnt_d;
		gtot_q <= gtot_d;
		n_q    <= n_d;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ready_d    = ready_q;
		total_d    = total_q;
		spacing_d  = spacing_q;
		qidx_d     = qidx_q;
		cur_d      = cur_q;
		r_d        = r_q;
		gcnt_d     = gcnt_q;
		gtot_d     = gtot_q;
		n_d        = n_q;
		flag_we    = 1'b0;
		stop_we    = 1'b0;
		out_valid  = 1'b0;
		split_done = 1'b0;
		div_req    = '0;

		unique case (state_q)
			crp_pkg::ST_IDLE: begin
				cur_d = '0;
				if (cfg_touch) begin
					ready_d = 1'b0;
				end
				if (accept) begin
					unique case (item.kind)
						crp_pkg::KIND_CLEAR: begin
							count_d = '0;
							ready_d = 1'b0;
						end
						crp_pkg::KIND_LOAD: begin
							if (count_q < crp_pkg::MAX_COUNT) begin
								flag_we = 1'b1;
								count_d = count_q + CW'(1);
							end
							ready_d = 1'b0;
						end
						crp_pkg::KIND_QUERY: begin
							qidx_d = item.range_index;
							if (ready_q) begin
								state_d = crp_pkg::ST_Q1;
							end else if (cfg.policy == crp_pkg::POLICY_GOOD) begin
								gtot_d  = '0;
								state_d = crp_pkg::ST_COUNT;
							end else begin
								n_d     = count_q;
								state_d = crp_pkg::ST_SPLIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			crp_pkg::ST_COUNT: begin
				if (cur_q < count_q) begin
					gtot_d = gtot_q + CW'(flag_s1);
					cur_d  = cur_q + CW'(1);
				end else begin
					n_d     = gtot_q;
					state_d = crp_pkg::ST_SPLIT;
				end
			end
			crp_pkg::ST_SPLIT: begin
				if (mode_cnt || mode_size) begin
					div_req.start    = 1'b1;
					div_req.dividend = n_q;
					div_req.divisor  = mode_cnt ? t_sat : cfg.target;
					state_d          = crp_pkg::ST_DIV;
				end else begin
					total_d    = CW'(1);
					spacing_d  = n_q;
					split_done = 1'b1;
				end
			end
			crp_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					if (mode_cnt) begin
						total_d   = t_sat;
						spacing_d = ceil_val;
					end else begin
						total_d   = ceil_val;
						spacing_d = cfg.target;
					end
					split_done = 1'b1;
				end
			end
			crp_pkg::ST_STOPS: begin
				if ((gcnt_q >= spacing_q) || (cur_q >= count_q)) begin
					stop_we = 1'b1;
					gcnt_d  = '0;
					if (r_ext == total_q - CW'(1)) begin
						ready_d = 1'b1;
						state_d = crp_pkg::ST_Q1;
					end else begin
						r_d = r_q + IW'(1);
					end
				end else begin
					gcnt_d = gcnt_q + CW'(flag_s1);
					cur_d  = cur_q + CW'(1);
				end
			end
			crp_pkg::ST_Q1: begin
				state_d = crp_pkg::ST_Q2;
			end
			crp_pkg::ST_Q2: begin
				out_valid = 1'b1;
				state_d   = crp_pkg::ST_IDLE;
			end
			default: begin
				state_d = crp_pkg::ST_IDLE;
			end
		endcase

		// no stops to walk for the spaced policy or when the partition holds no ranges
		if (split_done) begin
			if ((cfg.policy == crp_pkg::POLICY_GOOD) && (total_d != '0)) begin
				cur_d   = '0;
				r_d     = '0;
				gcnt_d  = '0;
				state_d = crp_pkg::ST_STOPS;
			end else begin
				ready_d = 1'b1;
				state_d = crp_pkg::ST_Q1;
			end
		end
	end

	assign busy = (state_q != crp_pkg::ST_IDLE);

	assign walking    = (state_q == crp_pkg::ST_COUNT) || (state_q == crp_pkg::ST_STOPS);
	assign fast_query = (state_q == crp_pkg::ST_IDLE) && accept
		&& (item.kind == crp_pkg::KIND_QUERY) && ready_q;

	`CRP_ASSERT_HOLD(a_result_ready, out_valid, ready_q, "result without a built partition")
	`CRP_ASSERT_HOLD(a_walk_bound, walking, cur_q <= count_q, "walk past channel count")
	`CRP_ASSERT_HOLD(a_range_bound, state_q == crp_pkg::ST_STOPS, r_ext < total_q, "range past total")
	`CRP_ASSERT_NEXT(a_fast_query, fast_query, state_q == crp_pkg::ST_Q1, "built partition rebuilt")

endmodule

`default_nettype wire

>>> hw/rtl/channel_range_partitioner.sv
// Channel range partitioner.
// Items enter on start/item and are taken when start is high and busy is low.
// A clear item empties the channel set; each load item appends one good flag
// (ignored once 4096 channels are held). Clears and loads give no result.
// A query returns start, stop, range count and an index error on result,
// marked by done for exactly one cycle; the receiver cannot stall.
// Query on a built partition: busy through states Q1 and Q2, done in the
// cycle after Q2. The first query after a clear, load or register write
// rebuilds the partition first, busy meanwhile:
//   evenly spaced: a split step, plus the 13-step serial divider when the
//   mode needs a division.
//   evenly distributed: counting good flags, the split (with the divider when
//   needed), then walking the flag memory, writing one range stop per range.
// The user must write registers through cfg_we/cfg_index/cfg_data only
// while idle, with no wait; the block itself does not enforce it. Reset
// clears registers, channel count and partition state; no memory clearing
// pass is needed.
`default_nettype none

module channel_range_partitioner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  crp_pkg::item_t                      item,
	output logic                                done,
	output crp_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [crp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	crp_pkg::cfg_t    cfg_q;
	logic             cfg_touch;
	logic             accept;
	logic             out_valid;
	crp_pkg::result_t out_item;
	logic             done_q;
	crp_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crp_pkg::REG_MODE:   cfg_q.mode   <= cfg_data[crp_pkg::MODE_W-1:0];
				crp_pkg::REG_TARGET: cfg_q.target <= cfg_data;
				crp_pkg::REG_POLICY: cfg_q.policy <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_touch = cfg_we && ((cfg_index == crp_pkg::REG_MODE)
		|| (cfg_index == crp_pkg::REG_TARGET) || (cfg_index == crp_pkg::REG_POLICY));
	assign accept = start && !busy;

	crp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg       (cfg_q),
		.cfg_touch (cfg_touch),
		.busy      (busy),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// result transfer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid) begin
			result_q <= out_item;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
